// File: src/dtc_pkg.sv
// Package for the decimal text to cents parser: types and character codes.
package dtc_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Fraction digits allowed after the separator
  localparam logic [1:0] FRAC_MAX = 2'd2;

  localparam int CENTS_W = 63;

  // Parser phase
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_NUM   = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  // Input word: one character of the amount text
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_word_t;

  // Result word
  typedef struct packed {
    logic               amount_ok;
    logic [CENTS_W-1:0] cents;
  } cents_word_t;

  // Finished amount waiting for its final scaling
  typedef struct packed {
    logic               ok_pre;
    logic [1:0]         frac;
    logic [CENTS_W-1:0] acc;
  } fin_word_t;

endpackage

// File: src/decimal_text_to_cents.sv
// Top level of the decimal text to cents parser.
//
// Takes an amount as text, one character word per cycle, with is_last set on
// the final character; gives one result word per amount: amount_ok and the
// value in hundredths (0 when not ok). A new character is accepted in every
// cycle unless in_stall is high, including right after a last character. The
// per-character digit step (multiply by ten and add) runs in the cycle the
// character is accepted; the final scaling to hundredths takes one more
// register stage, so a result passes the scaling stage and then the output
// register, where it waits until taken. Input stalls only when both the scaling
// stage and the output register are full and the output is stalled.
module decimal_text_to_cents
  import dtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  char_word_t  in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output cents_word_t out_word
);

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic               sep_r, sep_nxt;
  logic               int_r, int_nxt;
  logic [1:0]         frac_r, frac_nxt;
  logic [CENTS_W-1:0] acc_r, acc_nxt;
  logic               fail_r, fail_nxt;

  // Pipeline registers
  logic        fin_valid_r;
  fin_word_t   fin_r, fin_nxt;
  logic        out_valid_r;
  cents_word_t out_word_r, res_nxt;

  logic        adv;
  logic        in_acc;
  logic        is_blank, is_sep, is_digit;
  logic [66:0] push_val;
  logic        push_ovf;
  logic [69:0] prod;

  // Handshake
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = fin_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Character classes
  assign is_blank = (in_word.char_code == CH_SPACE) || (in_word.char_code == CH_TAB) ||
                    (in_word.char_code == CH_CR)    || (in_word.char_code == CH_LF);
  assign is_sep   = (in_word.char_code == CH_DOT) || (in_word.char_code == CH_COMMA);
  assign is_digit = (in_word.char_code >= CH_ZERO) && (in_word.char_code <= CH_NINE);

  // acc * 10 + digit; the digit is the low nibble of its code
  assign push_val = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                    {63'd0, in_word.char_code[3:0]};
  assign push_ovf = |push_val[66:CENTS_W];

  // Next parser state for the current character
  always_comb begin
    phase_nxt = phase_r;
    sep_nxt   = sep_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    acc_nxt   = acc_r;
    fail_nxt  = fail_r;
    if (!fail_r) begin
      unique case (phase_r)
        PH_LEAD, PH_NUM: begin
          if (is_blank) begin
            if (phase_r == PH_NUM) begin
              phase_nxt = PH_TRAIL;
            end
          end else begin
            phase_nxt = PH_NUM;
            if (is_sep) begin
              if (sep_r || !int_r) begin
                fail_nxt = 1'b1;
              end else begin
                sep_nxt = 1'b1;
              end
            end else if (is_digit) begin
              if (sep_r && (frac_r >= FRAC_MAX)) begin
                fail_nxt = 1'b1;
              end else begin
                if (sep_r) begin
                  frac_nxt = frac_r + 2'd1;
                end else begin
                  int_nxt = 1'b1;
                end
                if (push_ovf) begin
                  fail_nxt = 1'b1;
                end else begin
                  acc_nxt = push_val[CENTS_W-1:0];
                end
              end
            end else begin
              fail_nxt = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (!is_blank) begin
            fail_nxt = 1'b1;
          end
        end
        default: fail_nxt = 1'b1;
      endcase
    end
  end

  // Amount as it stands after the last character
  always_comb begin
    fin_nxt.ok_pre = !fail_nxt && (phase_nxt != PH_LEAD) && int_nxt &&
                     !(sep_nxt && (frac_nxt == 2'd0));
    fin_nxt.frac   = frac_nxt;
    fin_nxt.acc    = acc_nxt;
  end

  // Parser state registers; back to reset values after a last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      sep_r   <= 1'b0;
      int_r   <= 1'b0;
      frac_r  <= 2'd0;
      acc_r   <= '0;
      fail_r  <= 1'b0;
    end else if (in_acc) begin
      if (in_word.is_last) begin
        phase_r <= PH_LEAD;
        sep_r   <= 1'b0;
        int_r   <= 1'b0;
        frac_r  <= 2'd0;
        acc_r   <= '0;
        fail_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        sep_r   <= sep_nxt;
        int_r   <= int_nxt;
        frac_r  <= frac_nxt;
        acc_r   <= acc_nxt;
        fail_r  <= fail_nxt;
      end
    end
  end

  // Scale to hundredths: pad missing fraction digits with zeros
  always_comb begin
    unique case (fin_r.frac)
      2'd2:    prod = {7'd0, fin_r.acc};
      2'd1:    prod = {4'd0, fin_r.acc, 3'b000} + {6'd0, fin_r.acc, 1'b0};
      default: prod = {1'b0, fin_r.acc, 6'd0} + {2'd0, fin_r.acc, 5'd0} +
                      {5'd0, fin_r.acc, 2'b00};
    endcase
    res_nxt.amount_ok = fin_r.ok_pre && !(|prod[69:CENTS_W]) &&
                        (|prod[CENTS_W-1:0]);
    res_nxt.cents     = res_nxt.amount_ok ? prod[CENTS_W-1:0] : '0;
  end

  // Scaling stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_acc && in_word.is_last) begin
      fin_valid_r <= 1'b1;
    end else if (adv) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.is_last) begin
      fin_r <= fin_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid_r) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: test/tb.sv
// Testbench for decimal_text_to_cents: amount texts in, predicted cents words checked out.
module tb;
  import dtc_pkg::*;

  localparam logic [CENTS_W-1:0] CENTS_MAX = {CENTS_W{1'b1}};
  localparam int RANDOM_CHARS = 540;
  localparam int NOISE_CHARS  = 120;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  char_word_t  in_word;
  logic        out_valid;
  logic        out_stall;
  cents_word_t out_word;

  decimal_text_to_cents dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Parser state mirrored by the predictor
  phase_t      ph;
  logic        sep_seen;
  logic        int_seen;
  logic        failed;
  logic [1:0]  frac_cnt;
  logic [62:0] acc;

  cents_word_t cents_due[$];
  logic [7:0]  text_buf[$];
  int          fault_count;
  int          chars_sent;
  int          send_calm;
  int          recv_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait count for one word; occasional stretches with no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic clear_parser();
    ph       = PH_LEAD;
    sep_seen = 1'b0;
    int_seen = 1'b0;
    failed   = 1'b0;
    frac_cnt = 2'd0;
    acc      = '0;
  endtask

  // acc = acc * 10 + d, or fail if that passes the 63-bit range
  task automatic push_digit(input logic [3:0] d);
    logic [63:0] limit;
    limit = ({1'b0, CENTS_MAX} - 64'(d)) / 64'd10;
    if ({1'b0, acc} > limit) begin
      failed = 1'b1;
    end else begin
      acc = acc * 63'd10 + 63'(d);
    end
  endtask

  // Advance the predicted parser by one accepted word
  task automatic parse_char(input logic [7:0] c, input logic last);
    cents_word_t res;
    logic        ok;
    if (!failed) begin
      if (ph == PH_LEAD || ph == PH_NUM) begin
        if (is_blank(c)) begin
          if (ph == PH_NUM) ph = PH_TRAIL;
        end else begin
          ph = PH_NUM;
          if (c == CH_DOT || c == CH_COMMA) begin
            if (sep_seen || !int_seen) failed = 1'b1;
            else sep_seen = 1'b1;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (sep_seen && frac_cnt >= FRAC_MAX) begin
              failed = 1'b1;
            end else begin
              if (sep_seen) frac_cnt = frac_cnt + 2'd1;
              else int_seen = 1'b1;
              push_digit(4'(c - CH_ZERO));
            end
          end else begin
            failed = 1'b1;
          end
        end
      end else if (ph == PH_TRAIL) begin
        if (!is_blank(c)) failed = 1'b1;
      end else begin
        failed = 1'b1;
      end
    end
    if (last) begin
      ok = !failed && ph != PH_LEAD && int_seen;
      if (ok && sep_seen && frac_cnt == 2'd0) ok = 1'b0;
      if (ok) begin
        // scale to hundredths
        while (frac_cnt < FRAC_MAX && !failed) begin
          push_digit(4'd0);
          frac_cnt = frac_cnt + 2'd1;
        end
        if (failed || acc == '0) ok = 1'b0;
      end
      res.amount_ok = ok;
      res.cents     = ok ? acc : '0;
      cents_due.push_back(res);
      clear_parser();
    end
  endtask

  // Send one word; valid stays high into the next word when there is no gap
  task automatic send_char(input logic [7:0] c, input logic last);
    char_word_t w;
    int         gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.char_code = c;
    w.is_last   = last;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c, last);
    chars_sent++;
  endtask

  // Send text_buf as one amount, last flag on the final byte
  task automatic send_text();
    if (text_buf.size() == 0) text_buf.push_back(CH_SPACE);
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic send_str(input string s);
    text_buf.delete();
    add_str(s);
    send_text();
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Build a well-formed amount in text_buf, sometimes with one flaw
  task automatic make_amount();
    int    n_int;
    int    n_frac;
    int    pos;
    string top;
    text_buf.delete();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(rand_blank());
    case ($urandom_range(0, 9))
      0: begin
        // near the top of the 63-bit range
        top = "922337203685477";
        add_str(top.substr(0, $urandom_range(0, 14)));
        n_int = $urandom_range(1, 4);
      end
      1: n_int = $urandom_range(6, 19);
      default: n_int = $urandom_range(1, 5);
    endcase
    repeat (n_int) text_buf.push_back(rand_digit());
    if ($urandom_range(0, 2) != 0) begin
      text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
      n_frac = $urandom_range(1, 2);
      repeat (n_frac) text_buf.push_back(rand_digit());
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(rand_blank());
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 5))
        0: text_buf[pos] = 8'($urandom_range(0, 255));
        1: text_buf.insert(pos, rand_blank());
        2: text_buf.insert(pos, rand_digit());
        3: text_buf.insert(pos, $urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        4: text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        default: text_buf.delete(pos);
      endcase
    end
  endtask

  // Directed: extremes and each special case
  task automatic test_directed();
    send_str("0.01");
    send_str("9");
    send_str("12.34");
    text_buf.delete();
    add_str("  7,5 \t");
    text_buf.push_back(CH_CR);
    text_buf.push_back(CH_LF);
    send_text();
    text_buf.delete();
    add_str("\t ");
    text_buf.push_back(CH_CR);
    send_text();
    send_str(" ");
    send_str(".5");
    send_str("1..2");
    send_str("1.,2");
    send_str("1.234");
    send_str("1.");
    send_str("1 2");
    send_str("3 x");
    send_str("0");
    send_str("0,00");
    send_str("92233720368547758.07");
    send_str("92233720368547758.08");
    send_str("92233720368547759");
    send_str("99999999999999999999");
    send_str("1a2.3 4");
    text_buf.delete();
    add_str("5");
    text_buf.push_back(8'hFF);
    send_text();
    text_buf.delete();
    text_buf.push_back(8'h00);
    add_str("42");
    send_text();
  endtask

  // Random amounts, mostly well formed
  task automatic test_random_amounts();
    int start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      make_amount();
      send_text();
    end
  endtask

  // Random bytes with random last flags, biased toward parser characters
  task automatic test_noise();
    logic [7:0] c;
    for (int i = 0; i < NOISE_CHARS; i++) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(0, 255));
        1: c = rand_blank();
        2: c = $urandom_range(0, 1) ? CH_DOT : CH_COMMA;
        default: c = rand_digit();
      endcase
      send_char(c, i == NOISE_CHARS - 1 || $urandom_range(0, 7) == 0);
    end
  endtask

  // Output side: random stall, then take and check one result word
  initial begin
    int k;
    cents_word_t exp_w;
    recv_calm = 0;
    out_stall <= 1'b0;
    forever begin
      k = draw_wait(recv_calm);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
      if (cents_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result word: ok=%0b cents=%0d", out_word.amount_ok, out_word.cents);
      end else begin
        exp_w = cents_due.pop_front();
        if (out_word.amount_ok !== exp_w.amount_ok || out_word.cents !== exp_w.cents) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected ok=%0b cents=%0d, got ok=%0b cents=%0d",
                     exp_w.amount_ok, exp_w.cents, out_word.amount_ok, out_word.cents);
        end
      end
    end
  end

  // Run limit
  initial begin
    #5000000;
    $display("** decimal_text_to_cents: FAILED **");
    $finish;
  end

  initial begin
    int drain;
    fault_count = 0;
    chars_sent  = 0;
    send_calm   = 0;
    clear_parser();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_amounts();
    test_noise();

    // drain: drop valid at the last accept, wait for outstanding results
    in_valid <= 1'b0;
    drain = 0;
    while (cents_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (cents_due.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("** decimal_text_to_cents: PASSED **");
    end else begin
      $display("** decimal_text_to_cents: FAILED **");
    end
    $finish;
  end

endmodule
